// ===== design/tisp_pkg.sv =====
package tisp_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int TAG_W     = 16;
  localparam int TS_W      = 48;
  localparam int CNT_W     = 32;
  localparam int SUM_W     = 63;
  localparam int SIDX_W    = 4;
  localparam int S_DATA_W  = 72;
  localparam int M_DATA_W  = 296;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_END   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RESTART = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_IDLE    = 3'd4
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0] call_count;
    logic [SUM_W-1:0] total_ticks;
    logic [TS_W-1:0]  longest;
    logic [TS_W-1:0]  second_longest;
    logic [TS_W-1:0]  shortest;
    logic [TS_W-1:0]  second_shortest;
  } stats_t;

endpackage

// ===== design/tisp_lookup.sv =====
module tisp_lookup
  import tisp_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             used [SLOTS],
  input  logic [TAG_W-1:0] key  [SLOTS],
  input  logic [TAG_W-1:0] tag,
  output logic             hit,
  output logic [IDX_W-1:0] hit_idx,
  output logic             free,
  output logic [IDX_W-1:0] free_idx
);

  // lowest matching slot and lowest free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used[i] && (key[i] == tag)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!used[i]) begin
        free     = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

endmodule

// ===== design/tisp_record.sv =====
module tisp_record
  import tisp_pkg::*;
(
  input  stats_t          cur,
  input  logic [TS_W-1:0] interval,
  output stats_t          nxt
);

  logic [SUM_W:0] sum;

  always_comb begin
    nxt = cur;
    if (cur.second_longest < interval) begin
      if (cur.longest < interval) begin
        nxt.second_longest = cur.longest;
        nxt.longest        = interval;
      end else begin
        nxt.second_longest = interval;
      end
    end else if ((cur.second_shortest > interval) || (cur.second_shortest == '0)) begin
      if ((cur.shortest > interval) || (cur.shortest == '0)) begin
        nxt.second_shortest = cur.shortest;
        nxt.shortest        = interval;
      end else begin
        nxt.second_shortest = interval;
      end
    end
    sum = {1'b0, cur.total_ticks} + (SUM_W + 1)'(interval);
    nxt.total_ticks = sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
  end

endmodule

// ===== design/tagged_interval_stats_profiler_top.sv =====
// Tagged interval profiler: begin, end and clear events enter on the slave
// stream and each returns one result beat on the master stream. An event is
// taken every cycle unless the master side stalls, and its result is registered:
// from the input register, the tag compare over all slots and the slot statistics
// update settle combinationally into the result register.
// Backpressure on the master side stalls both stages.
module tagged_interval_stats_profiler_top
  import tisp_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // req_type[1:0], tag[17:2], timestamp[65:18]
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // status[2:0], slot_index[6:3], call_count[38:7], total_ticks[101:39],
  // longest[149:102], second_longest[197:150], shortest[245:198],
  // second_shortest[293:246]
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic             used    [SLOTS];
  logic [TAG_W-1:0] key     [SLOTS];
  logic             running [SLOTS];
  logic [TS_W-1:0]  stamp   [SLOTS];
  stats_t           stats   [SLOTS];

  logic             in_valid;
  req_t             in_req;
  logic [TAG_W-1:0] in_tag;
  logic [TS_W-1:0]  in_ts;

  logic             out_valid;
  status_t          out_status;
  logic [SIDX_W-1:0] out_idx;
  stats_t           out_stats;

  logic             advance;
  logic             fire;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] sel_idx;
  stats_t           sel_stats;
  stats_t           rec_stats;
  logic [TS_W-1:0]  interval;

  status_t          status_next;
  logic             report;
  stats_t           stats_next;
  logic             wr_stats;
  logic             wr_start;
  logic             wr_stop;
  logic             wr_claim;
  logic             do_clear;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req <= req_t'(s_tdata[1:0]);
      in_tag <= s_tdata[17:2];
      in_ts  <= s_tdata[65:18];
    end
  end

  tisp_lookup #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_lookup (
    .used     (used),
    .key      (key),
    .tag      (in_tag),
    .hit      (hit),
    .hit_idx  (hit_idx),
    .free     (free),
    .free_idx (free_idx)
  );

  assign sel_idx   = hit ? hit_idx : free_idx;
  assign sel_stats = stats[sel_idx];
  assign interval  = in_ts - stamp[sel_idx];

  tisp_record u_record (
    .cur      (sel_stats),
    .interval (interval),
    .nxt      (rec_stats)
  );

  always_comb begin
    status_next = ST_OK;
    report      = 1'b0;
    stats_next  = sel_stats;
    wr_stats    = 1'b0;
    wr_start    = 1'b0;
    wr_stop     = 1'b0;
    wr_claim    = 1'b0;
    do_clear    = 1'b0;
    unique case (in_req)
      REQ_BEGIN: begin
        if (hit && running[hit_idx]) begin
          status_next = ST_RESTART;
          report      = 1'b1;
          wr_start    = 1'b1;
        end else if (hit || free) begin
          report   = 1'b1;
          wr_start = 1'b1;
          wr_stats = 1'b1;
          wr_claim = !hit;
          if (sel_stats.call_count != {CNT_W{1'b1}}) begin
            stats_next.call_count = sel_stats.call_count + 1'b1;
          end
        end else begin
          status_next = ST_FULL;
        end
      end
      REQ_END: begin
        if (!hit) begin
          status_next = ST_UNKNOWN;
        end else if (!running[hit_idx]) begin
          status_next = ST_IDLE;
          report      = 1'b1;
        end else begin
          report     = 1'b1;
          stats_next = rec_stats;
          wr_stats   = 1'b1;
          wr_stop    = 1'b1;
        end
      end
      REQ_CLEAR: begin
        do_clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // unused slots hold zero statistics, so clear may wipe every slot
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        used[i]    <= 1'b0;
        running[i] <= 1'b0;
        stats[i]   <= '0;
      end
    end else if (fire) begin
      if (do_clear) begin
        for (int i = 0; i < SLOTS; i++) begin
          running[i] <= 1'b0;
          stats[i]   <= '0;
        end
      end else begin
        if (wr_claim) begin
          used[sel_idx] <= 1'b1;
        end
        if (wr_start) begin
          running[sel_idx] <= 1'b1;
        end
        if (wr_stop) begin
          running[sel_idx] <= 1'b0;
        end
        if (wr_stats) begin
          stats[sel_idx] <= stats_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (wr_claim) begin
        key[sel_idx] <= in_tag;
      end
      if (wr_start) begin
        stamp[sel_idx] <= in_ts;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= status_next;
      out_idx    <= report ? SIDX_W'(sel_idx) : '0;
      out_stats  <= report ? stats_next : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_stats.second_shortest, out_stats.shortest,
                     out_stats.second_longest, out_stats.longest,
                     out_stats.total_ticks, out_stats.call_count,
                     out_idx, out_status};

endmodule

// ===== tb/sv/tb_tagged_interval_stats_profiler_top.sv =====
`timescale 1ns / 100ps

module tb_tagged_interval_stats_profiler_top;
  import tisp_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_PAIRS = 16;
  localparam int RAND_ITEMS = 1500;
  localparam logic [TS_W-1:0] TS_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    req_t             req;
    logic [TAG_W-1:0] tag;
    logic [TS_W-1:0]  stamp;
  } prof_ev_t;

  typedef struct packed {
    status_t           status;
    logic [SIDX_W-1:0] slot;
    stats_t            stats;
  } prof_rsp_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  tagged_interval_stats_profiler_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  bit               busy [NSLOT];
  logic [TAG_W-1:0] key [NSLOT];
  bit               timing [NSLOT];
  logic [TS_W-1:0]  t0 [NSLOT];
  logic [CNT_W-1:0] starts [NSLOT];
  logic [SUM_W-1:0] sum [NSLOT];
  logic [TS_W-1:0]  hi1 [NSLOT];
  logic [TS_W-1:0]  hi2 [NSLOT];
  logic [TS_W-1:0]  lo1 [NSLOT];
  logic [TS_W-1:0]  lo2 [NSLOT];

  prof_ev_t  event_feed [$];
  prof_rsp_t stat_reports [$];
  prof_ev_t  cur_event;
  bit        failed = 1'b0;
  bit        send_gap;
  int        sent_cnt = 0;
  int        rcvd_cnt = 0;
  int        holdoff_left = 0;
  bit        holdoff_done = 1'b0;
  int        quiet_cycles = 0;
  prof_rsp_t want;

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      busy[i] = 1'b0;
      key[i] = '0;
      timing[i] = 1'b0;
      t0[i] = '0;
      starts[i] = '0;
      sum[i] = '0;
      hi1[i] = '0;
      hi2[i] = '0;
      lo1[i] = '0;
      lo2[i] = '0;
    end
  end

  function automatic void fresh_start(int s, logic [TS_W-1:0] ts);
    if (starts[s] != '1) starts[s] = starts[s] + 1'b1;
    timing[s] = 1'b1;
    t0[s] = ts;
  endfunction

  function automatic prof_rsp_t profile_event(prof_ev_t ev);
    prof_rsp_t   rsp;
    int          hit;
    int          s;
    logic [TS_W-1:0] span;
    logic [63:0] acc;
    rsp = '0;
    rsp.status = ST_OK;
    hit = -1;
    s = -1;
    for (int i = 0; i < NSLOT; i++)
      if (hit < 0 && busy[i] && key[i] == ev.tag) hit = i;
    case (ev.req)
      REQ_BEGIN: begin
        if (hit >= 0) begin
          s = hit;
          if (timing[s]) begin
            t0[s] = ev.stamp;
            rsp.status = ST_RESTART;
          end else begin
            fresh_start(s, ev.stamp);
          end
        end else begin
          for (int i = 0; i < NSLOT; i++)
            if (s < 0 && !busy[i]) s = i;
          if (s >= 0) begin
            busy[s] = 1'b1;
            key[s] = ev.tag;
            fresh_start(s, ev.stamp);
          end else begin
            rsp.status = ST_FULL;
          end
        end
      end
      REQ_END: begin
        if (hit < 0) begin
          rsp.status = ST_UNKNOWN;
        end else if (!timing[hit]) begin
          s = hit;
          rsp.status = ST_IDLE;
        end else begin
          s = hit;
          span = ev.stamp - t0[s];
          if (hi2[s] < span) begin
            if (hi1[s] < span) begin
              hi2[s] = hi1[s];
              hi1[s] = span;
            end else begin
              hi2[s] = span;
            end
          end else if (lo2[s] > span || lo2[s] == 0) begin
            if (lo1[s] > span || lo1[s] == 0) begin
              lo2[s] = lo1[s];
              lo1[s] = span;
            end else begin
              lo2[s] = span;
            end
          end
          acc = 64'(sum[s]) + 64'(span);
          sum[s] = (acc > 64'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
          timing[s] = 1'b0;
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < NSLOT; i++)
          if (busy[i]) begin
            starts[i] = '0;
            sum[i] = '0;
            hi1[i] = '0;
            hi2[i] = '0;
            lo1[i] = '0;
            lo2[i] = '0;
            timing[i] = 1'b0;
          end
      end
      default: ;
    endcase
    if (s >= 0) begin
      rsp.slot = s[SIDX_W-1:0];
      rsp.stats.call_count = starts[s];
      rsp.stats.total_ticks = sum[s];
      rsp.stats.longest = hi1[s];
      rsp.stats.second_longest = hi2[s];
      rsp.stats.shortest = lo1[s];
      rsp.stats.second_shortest = lo2[s];
    end
    return rsp;
  endfunction

  function automatic logic [TS_W-1:0] rand48();
    return {16'($urandom_range(0, 65535)), 32'($urandom())};
  endfunction

  // mix of short, medium and long gaps, some wrapping the counter
  function automatic logic [TS_W-1:0] next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 48'($urandom_range(0, 15));
    if (r < 70) return 48'($urandom_range(0, 65535));
    if (r < 90) return 48'($urandom());
    return rand48();
  endfunction

  task automatic queue_event(req_t r, logic [TAG_W-1:0] t, logic [TS_W-1:0] ts);
    prof_ev_t ev;
    ev.req = r;
    ev.tag = t;
    ev.stamp = ts;
    event_feed.push_back(ev);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      failed = 1'b1;
    end
  endtask

  // stimulus
  initial begin
    logic [TAG_W-1:0] pool [NSLOT];
    bit               gen_open [NSLOT];
    logic [TS_W-1:0]  now;
    logic [TS_W-1:0]  ts;
    int               r;
    int               k;
    int               pick;

    pool[0] = 16'h0000;
    pool[1] = 16'hFFFF;
    for (int i = 2; i < NSLOT; i++) pool[i] = 16'(i - 1);
    for (int i = 0; i < NSLOT; i++) gen_open[i] = 1'b0;

    queue_event(REQ_NONE, 16'h1234, rand48());
    queue_event(REQ_END, 16'hFFFF, rand48());
    queue_event(REQ_CLEAR, 16'h5A5A, rand48());
    queue_event(REQ_BEGIN, 16'h0000, 48'd0);
    queue_event(REQ_BEGIN, 16'h0000, 48'd5);
    queue_event(REQ_END, 16'h0000, TS_MAX);
    queue_event(REQ_END, 16'h0000, 48'd7);
    queue_event(REQ_BEGIN, 16'hFFFF, TS_MAX);
    queue_event(REQ_END, 16'hFFFF, 48'd0);
    queue_event(REQ_BEGIN, 16'hFFFF, 48'd100);
    queue_event(REQ_END, 16'hFFFF, 48'd100);
    for (int i = 2; i < NSLOT; i++) queue_event(REQ_BEGIN, pool[i], rand48());
    queue_event(REQ_BEGIN, 16'h8000, rand48());
    queue_event(REQ_CLEAR, 16'h0000, TS_MAX);

    // maximal intervals on one tag
    for (int i = 0; i < LONG_PAIRS; i++) begin
      ts = rand48();
      queue_event(REQ_BEGIN, pool[4], ts);
      queue_event(REQ_END, pool[4], ts - 1'b1);
    end
    queue_event(REQ_CLEAR, pool[4], rand48());

    now = rand48();
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      now = now + next_gap();
      if (r < 3) begin
        queue_event(REQ_CLEAR, 16'($urandom()), rand48());
        for (int i = 0; i < NSLOT; i++) gen_open[i] = 1'b0;
      end else if (r < 5) begin
        queue_event(REQ_NONE, 16'($urandom()), rand48());
      end else if (r < 12) begin
        queue_event(($urandom_range(0, 1) != 0) ? REQ_BEGIN : REQ_END,
                    16'($urandom()), now);
      end else if (r < 52) begin
        k = $urandom_range(0, NSLOT - 1);
        pick = k;
        if ($urandom_range(0, 9) != 0)
          for (int i = 0; i < NSLOT; i++)
            if (gen_open[(k + i) % NSLOT] && pick == k && !gen_open[k])
              pick = (k + i) % NSLOT;
        queue_event(REQ_END, pool[pick], now);
        gen_open[pick] = 1'b0;
      end else begin
        k = $urandom_range(0, NSLOT - 1);
        queue_event(REQ_BEGIN, pool[k], now);
        gen_open[k] = 1'b1;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (event_feed.size() != 0 || s_tvalid || stat_reports.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
    if (!failed) begin
      $display("tagged_interval_stats_profiler_top test passed");
    end else begin
      $display("tagged_interval_stats_profiler_top test failed");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        stat_reports.push_back(profile_event(cur_event));
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_tvalid || s_tready) begin
        send_gap = !(sent_cnt >= 1000 && sent_cnt < 1600) && $urandom_range(0, 99) < 32;
        if (event_feed.size() != 0 && !send_gap) begin
          cur_event = event_feed.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {6'd0, cur_event.stamp, cur_event.tag, cur_event.req};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (stat_reports.size() == 0) begin
          $error("result beat with no event outstanding");
          failed = 1'b1;
        end else begin
          want = stat_reports.pop_front();
          check_field("status", 64'(want.status), 64'(m_tdata[2:0]));
          check_field("slot_index", 64'(want.slot), 64'(m_tdata[6:3]));
          check_field("call_count", 64'(want.stats.call_count), 64'(m_tdata[38:7]));
          check_field("total_ticks", 64'(want.stats.total_ticks), 64'(m_tdata[101:39]));
          check_field("longest", 64'(want.stats.longest), 64'(m_tdata[149:102]));
          check_field("second_longest", 64'(want.stats.second_longest),
                      64'(m_tdata[197:150]));
          check_field("shortest", 64'(want.stats.shortest), 64'(m_tdata[245:198]));
          check_field("second_shortest", 64'(want.stats.second_shortest),
                      64'(m_tdata[293:246]));
        end
        rcvd_cnt <= rcvd_cnt + 1;
      end
      m_tready <= (holdoff_left == 0) &&
                  ((rcvd_cnt >= 1000 && rcvd_cnt < 1600) || $urandom_range(0, 99) >= 32);
    end
  end

  // one long receiver stall to back the pipeline up
  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
    end else if (!holdoff_done && rcvd_cnt == 600) begin
      holdoff_left <= 300;
      holdoff_done <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tagged_interval_stats_profiler_top test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

// ===== sim.f =====
design/tisp_pkg.sv
design/tisp_lookup.sv
design/tisp_record.sv
design/tagged_interval_stats_profiler_top.sv
tb/sv/tb_tagged_interval_stats_profiler_top.sv
